// ===== rtl/core/sle_pkg.sv =====
// ============================================================================
// Serial line editor package
// Shared types, codes, character constants and the control store.
// ============================================================================
package sle_pkg;

    localparam int SLE_LINE_CAPACITY = 16;

    // Result kinds
    localparam logic [1:0] K_ECHO = 2'd0;
    localparam logic [1:0] K_LINE = 2'd1;
    localparam logic [1:0] K_EOF  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // Characters
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DC2 = 8'h12;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ETB = 8'h17;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TLD = 8'h7E;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_NBS = 8'hA0;

    // Request classes
    typedef logic [3:0] t_cls;
    localparam t_cls CL_NONE    = 4'd0;
    localparam t_cls CL_EOF     = 4'd1;
    localparam t_cls CL_ERR     = 4'd2;
    localparam t_cls CL_LINE    = 4'd3;
    localparam t_cls CL_PRINT   = 4'd4;
    localparam t_cls CL_ERASE   = 4'd5;
    localparam t_cls CL_REPRINT = 4'd6;
    localparam t_cls CL_KILL    = 4'd7;
    localparam t_cls CL_WERASE  = 4'd8;

    // Sequencer operations
    localparam logic [2:0] SQ_ADV  = 3'd0;
    localparam logic [2:0] SQ_JMP  = 3'd1;
    localparam logic [2:0] SQ_JIF  = 3'd2;
    localparam logic [2:0] SQ_DISP = 3'd3;
    localparam logic [2:0] SQ_IDLE = 3'd4;
    localparam logic [2:0] SQ_FIN  = 3'd5;

    // Jump conditions
    localparam logic [1:0] CD_FILL_ZERO = 2'd0;
    localparam logic [1:0] CD_FULL      = 2'd1;
    localparam logic [1:0] CD_IDX_END   = 2'd2;
    localparam logic [1:0] CD_RD_SPACE  = 2'd3;

    // Character sources
    localparam logic [1:0] CS_CONST = 2'd0;
    localparam logic [1:0] CS_BYTE  = 2'd1;
    localparam logic [1:0] CS_RDATA = 2'd2;

    // Counter operations
    localparam logic [1:0] CO_HOLD = 2'd0;
    localparam logic [1:0] CO_CLR  = 2'd1;
    localparam logic [1:0] CO_INC  = 2'd2;
    localparam logic [1:0] CO_DEC  = 2'd3;

    // Read address select
    localparam logic RS_IDX    = 1'b0;
    localparam logic RS_FILLM1 = 1'b1;

    typedef logic [4:0] t_step;

    localparam t_step ST_IDLE      = 5'd0;
    localparam t_step ST_DISP      = 5'd1;
    localparam t_step ST_EOF       = 5'd2;
    localparam t_step ST_ERR       = 5'd3;
    localparam t_step ST_LINE      = 5'd4;
    localparam t_step ST_LINE_LOOP = 5'd5;
    localparam t_step ST_LINE_CHAR = 5'd6;
    localparam t_step ST_LINE_NL   = 5'd7;
    localparam t_step ST_PRINT     = 5'd8;
    localparam t_step ST_STORE     = 5'd9;
    localparam t_step ST_BELL      = 5'd10;
    localparam t_step ST_ERASE     = 5'd11;
    localparam t_step ST_ER_BS1    = 5'd12;
    localparam t_step ST_ER_SP     = 5'd13;
    localparam t_step ST_ER_BS2    = 5'd14;
    localparam t_step ST_KILL      = 5'd15;
    localparam t_step ST_KL_BS1    = 5'd16;
    localparam t_step ST_KL_SP     = 5'd17;
    localparam t_step ST_KL_BS2    = 5'd18;
    localparam t_step ST_WERASE    = 5'd19;
    localparam t_step ST_WE_CHK    = 5'd20;
    localparam t_step ST_WE_BS1    = 5'd21;
    localparam t_step ST_WE_SP     = 5'd22;
    localparam t_step ST_WE_BS2    = 5'd23;
    localparam t_step ST_REPRINT   = 5'd24;
    localparam t_step ST_RP_LOOP   = 5'd25;
    localparam t_step ST_RP_CHAR   = 5'd26;
    localparam t_step ST_FIN       = 5'd27;

    typedef struct packed {
        logic [2:0] seq_op;
        logic [1:0] cond;
        t_step      target;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] csrc;
        logic [7:0] cchar;
        logic [1:0] fill_op;
        logic [1:0] idx_op;
        logic       wr;
        logic       rd;
        logic       rd_sel;
    } t_uword;

    typedef struct packed {
        logic       idle;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] csrc;
        logic [7:0] cchar;
        logic [1:0] fill_op;
        logic [1:0] idx_op;
        logic       wr;
        logic       rd;
        logic       rd_sel;
        logic       flush;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        t_cls cls;
        logic fill_zero;
        logic full;
        logic idx_end;
        logic rd_space;
        logic out_block;
    } t_flags;

    function automatic logic [7:0] sle_norm(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_CR) r = CH_NL;
        if (c == CH_TAB) r = CH_SP;
        return r;
    endfunction

    function automatic t_cls sle_classify(input logic [7:0] c, input logic fe,
                                          input logic ovr);
        t_cls r;
        priority if (fe) r = CL_EOF;
        else if (ovr) r = CL_ERR;
        else if (c == CH_NL) r = CL_LINE;
        else if ((c >= CH_SP && c <= CH_TLD) || c >= CH_NBS) r = CL_PRINT;
        else if (c == CH_ETX) r = CL_ERR;
        else if (c == CH_BS || c == CH_DEL) r = CL_ERASE;
        else if (c == CH_DC2) r = CL_REPRINT;
        else if (c == CH_NAK) r = CL_KILL;
        else if (c == CH_ETB) r = CL_WERASE;
        else r = CL_NONE;
        return r;
    endfunction

    function automatic t_step sle_entry(input t_cls cls);
        t_step r;
        unique case (cls)
            CL_EOF:     r = ST_EOF;
            CL_ERR:     r = ST_ERR;
            CL_LINE:    r = ST_LINE;
            CL_PRINT:   r = ST_PRINT;
            CL_ERASE:   r = ST_ERASE;
            CL_REPRINT: r = ST_REPRINT;
            CL_KILL:    r = ST_KILL;
            CL_WERASE:  r = ST_WERASE;
            default:    r = ST_FIN;
        endcase
        return r;
    endfunction

    function automatic t_uword sle_ucode(input t_step step);
        t_uword u;
        u = '0;
        u.seq_op = SQ_ADV;
        unique case (step)
            ST_IDLE: u.seq_op = SQ_IDLE;
            ST_DISP: u.seq_op = SQ_DISP;
            ST_EOF: begin
                u.emit = 1'b1; u.kind = K_EOF; u.fill_op = CO_CLR;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_ERR: begin
                u.emit = 1'b1; u.kind = K_ERR; u.fill_op = CO_CLR;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_LINE: begin
                u.emit = 1'b1; u.cchar = CH_NL; u.idx_op = CO_CLR;
            end
            ST_LINE_LOOP: begin
                u.seq_op = SQ_JIF; u.cond = CD_IDX_END; u.target = ST_LINE_NL;
                u.rd = 1'b1; u.rd_sel = RS_IDX;
            end
            ST_LINE_CHAR: begin
                u.emit = 1'b1; u.kind = K_LINE; u.csrc = CS_RDATA; u.idx_op = CO_INC;
                u.seq_op = SQ_JMP; u.target = ST_LINE_LOOP;
            end
            ST_LINE_NL: begin
                u.emit = 1'b1; u.kind = K_LINE; u.cchar = CH_NL; u.fill_op = CO_CLR;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_PRINT: begin
                u.seq_op = SQ_JIF; u.cond = CD_FULL; u.target = ST_BELL;
            end
            ST_STORE: begin
                u.wr = 1'b1; u.fill_op = CO_INC; u.emit = 1'b1; u.csrc = CS_BYTE;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_BELL: begin
                u.emit = 1'b1; u.cchar = CH_BEL;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_ERASE: begin
                u.seq_op = SQ_JIF; u.cond = CD_FILL_ZERO; u.target = ST_FIN;
            end
            ST_ER_BS1: begin u.emit = 1'b1; u.cchar = CH_BS; end
            ST_ER_SP:  begin u.emit = 1'b1; u.cchar = CH_SP; end
            ST_ER_BS2: begin
                u.emit = 1'b1; u.cchar = CH_BS; u.fill_op = CO_DEC;
                u.seq_op = SQ_JMP; u.target = ST_FIN;
            end
            ST_KILL: begin
                u.seq_op = SQ_JIF; u.cond = CD_FILL_ZERO; u.target = ST_FIN;
            end
            ST_KL_BS1: begin u.emit = 1'b1; u.cchar = CH_BS; end
            ST_KL_SP:  begin u.emit = 1'b1; u.cchar = CH_SP; end
            ST_KL_BS2: begin
                u.emit = 1'b1; u.cchar = CH_BS; u.fill_op = CO_DEC;
                u.seq_op = SQ_JMP; u.target = ST_KILL;
            end
            ST_WERASE: begin
                u.seq_op = SQ_JIF; u.cond = CD_FILL_ZERO; u.target = ST_FIN;
                u.rd = 1'b1; u.rd_sel = RS_FILLM1;
            end
            ST_WE_CHK: begin
                u.seq_op = SQ_JIF; u.cond = CD_RD_SPACE; u.target = ST_FIN;
            end
            ST_WE_BS1: begin u.emit = 1'b1; u.cchar = CH_BS; end
            ST_WE_SP:  begin u.emit = 1'b1; u.cchar = CH_SP; end
            ST_WE_BS2: begin
                u.emit = 1'b1; u.cchar = CH_BS; u.fill_op = CO_DEC;
                u.seq_op = SQ_JMP; u.target = ST_WERASE;
            end
            ST_REPRINT: begin
                u.emit = 1'b1; u.cchar = CH_CR; u.idx_op = CO_CLR;
            end
            ST_RP_LOOP: begin
                u.seq_op = SQ_JIF; u.cond = CD_IDX_END; u.target = ST_FIN;
                u.rd = 1'b1; u.rd_sel = RS_IDX;
            end
            ST_RP_CHAR: begin
                u.emit = 1'b1; u.csrc = CS_RDATA; u.idx_op = CO_INC;
                u.seq_op = SQ_JMP; u.target = ST_RP_LOOP;
            end
            default: u.seq_op = SQ_FIN;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/serial_line_editor_top.sv =====
// ============================================================================
// Serial line editor
// Canonical line editing of a received byte stream, run by a microsequencer.
// ============================================================================
//  Channel | Handshake          | Fields
//  in      | i_valid / o_stall  | i_rx_byte, i_framing_error, i_overrun
//  out     | o_valid / i_stall  | o_kind, o_out_char, o_last
//
//  One request at a time; the sequencer steps once per cycle through the control store
//  unless a stalled output holds it. A request is taken only in the idle step, so the
//  next one waits until the current one is finished and the sequencer is idle again.
//  Results leave through a one-deep staging register and an output register;
//  a stalled output holds the sequencer at its next emit or finish step.
//  Synchronous reset empties the line; the line store itself is not cleared.
module serial_line_editor_top #(
    parameter int LINE_CAPACITY = sle_pkg::SLE_LINE_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_framing_error,
    input  logic       i_overrun,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    import sle_pkg::*;

    localparam int FW = $clog2(LINE_CAPACITY);
    localparam logic [FW-1:0] FULL_AT = FW'(LINE_CAPACITY - 1);

    t_ctrl         ctrl;
    t_flags        flags;
    logic          accept;
    logic [7:0]    r_byte;
    t_cls          r_cls;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_idx;
    logic [FW-1:0] raddr;
    logic [7:0]    rdata;
    logic [7:0]    emit_char;
    logic          r_pend_valid;
    logic [1:0]    r_pend_kind;
    logic [7:0]    r_pend_char;
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_char;
    logic          r_out_last;

    sle_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign raddr = (ctrl.rd_sel == RS_FILLM1) ? r_fill - FW'(1) : r_idx;

    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ctrl.wr),
        .i_waddr (r_fill),
        .i_wdata (r_byte),
        .i_re    (ctrl.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_stall = !ctrl.idle;
    assign accept  = i_valid && ctrl.idle;

    always_comb begin
        flags.in_valid  = i_valid;
        flags.cls       = r_cls;
        flags.fill_zero = (r_fill == '0);
        flags.full      = (r_fill >= FULL_AT);
        flags.idx_end   = (r_idx == r_fill);
        flags.rd_space  = (rdata == CH_SP);
        flags.out_block = r_pend_valid && r_out_valid && i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= sle_norm(i_rx_byte);
            r_cls  <= sle_classify(sle_norm(i_rx_byte), i_framing_error, i_overrun);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            unique case (ctrl.fill_op)
                CO_CLR:  r_fill <= '0;
                CO_INC:  r_fill <= r_fill + FW'(1);
                CO_DEC:  r_fill <= r_fill - FW'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (ctrl.idx_op)
            CO_CLR:  r_idx <= '0;
            CO_INC:  r_idx <= r_idx + FW'(1);
            default: r_idx <= r_idx;
        endcase
    end

    always_comb begin
        unique case (ctrl.csrc)
            CS_BYTE:  emit_char = r_byte;
            CS_RDATA: emit_char = rdata;
            default:  emit_char = ctrl.cchar;
        endcase
    end

    // Stage each result one step so the final one can be marked last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ctrl.emit) begin
                r_pend_valid <= 1'b1;
            end else if (ctrl.flush && r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end
            if ((ctrl.emit || ctrl.flush) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            if (r_pend_valid) begin
                r_out_kind <= r_pend_kind;
                r_out_char <= r_pend_char;
                r_out_last <= 1'b0;
            end
            r_pend_kind <= ctrl.kind;
            r_pend_char <= emit_char;
        end else if (ctrl.flush && r_pend_valid) begin
            r_out_kind <= r_pend_kind;
            r_out_char <= r_pend_char;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

endmodule

// ===== rtl/core/sle_ram.sv =====
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sle_seq.sv =====
// ============================================================================
// Serial line editor sequencer
// Step counter over the control store, with dispatch and conditional jumps.
// ============================================================================
module sle_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sle_pkg::t_flags i_flags,
    output sle_pkg::t_ctrl  o_ctrl
);

    import sle_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   cond_true;
    logic   hold;

    assign uw = sle_ucode(r_step);

    always_comb begin
        unique case (uw.cond)
            CD_FILL_ZERO: cond_true = i_flags.fill_zero;
            CD_FULL:      cond_true = i_flags.full;
            CD_IDX_END:   cond_true = i_flags.idx_end;
            CD_RD_SPACE:  cond_true = i_flags.rd_space;
            default:      cond_true = 1'b0;
        endcase
    end

    // Wait while the staged result cannot move on
    assign hold = (uw.emit || uw.seq_op == SQ_FIN) && i_flags.out_block;

    always_comb begin
        unique case (uw.seq_op)
            SQ_IDLE: n_step = i_flags.in_valid ? ST_DISP : r_step;
            SQ_ADV:  n_step = r_step + t_step'(1);
            SQ_JMP:  n_step = uw.target;
            SQ_JIF:  n_step = cond_true ? uw.target : r_step + t_step'(1);
            SQ_DISP: n_step = sle_entry(i_flags.cls);
            SQ_FIN:  n_step = ST_IDLE;
            default: n_step = ST_IDLE;
        endcase
        if (hold) n_step = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_ctrl.idle    = (uw.seq_op == SQ_IDLE);
        o_ctrl.emit    = uw.emit && !hold;
        o_ctrl.kind    = uw.kind;
        o_ctrl.csrc    = uw.csrc;
        o_ctrl.cchar   = uw.cchar;
        o_ctrl.fill_op = hold ? CO_HOLD : uw.fill_op;
        o_ctrl.idx_op  = hold ? CO_HOLD : uw.idx_op;
        o_ctrl.wr      = uw.wr && !hold;
        o_ctrl.rd      = uw.rd && !hold;
        o_ctrl.rd_sel  = uw.rd_sel;
        o_ctrl.flush   = (uw.seq_op == SQ_FIN) && !hold;
    end

endmodule

// ===== rtl/core/sle_chk.sv =====
// ============================================================================
// Serial line editor checker
// Port-level properties of the line editor, bound to the top level.
// ============================================================================
module sle_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_rx_byte,
    input logic       i_framing_error,
    input logic       i_overrun,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_char,
    input logic       o_last
);

    import sle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_out_char)
            && $stable(o_last))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without going busy");

    a_flag_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_EOF || o_kind == K_ERR) |-> o_out_char == 8'h00 && o_last)
        else $error("end of file or error carries a character or is not last");

    a_line_nl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_LINE && o_out_char == CH_NL |-> o_last)
        else $error("line terminator not last");

endmodule

bind serial_line_editor_top sle_chk u_sle_chk (.*);
